/* hdl/wrwt_pkg.sv */
// ----------------------------------------------------------------------------
// wrwt_pkg
// Shared types, field widths and defaults of the work-request wrap tracker.
// ----------------------------------------------------------------------------
package wrwt_pkg;

    // Default table sizing
    localparam int COMM_SLOTS_DEF     = 16;
    localparam int RANKS_PER_COMM_DEF = 64;
    localparam int BOX_RANKS_DEF      = 8;
    localparam int COUNTER_BITS_DEF   = 16;

    // Field widths of the stream words
    localparam int MODE_BITS     = 1;
    localparam int KIND_BITS     = 2;
    localparam int COMM_BITS     = 4;
    localparam int RANK_BITS     = 6;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 8;

    // Wrap size register
    localparam int              WRAP_BITS    = 4;
    localparam logic [WRAP_BITS-1:0] WRAP_LOG2_RST = 4'd3;

    typedef enum logic {
        MODE_INC   = 1'b0,
        MODE_FETCH = 1'b1
    } t_mode;

    // Control part of a classified item
    typedef struct packed {
        t_mode mode;
        logic  bad;
    } t_cmd_ctl;

    // Result word, notify_ack in the lowest bit
    typedef struct packed {
        logic bad_rank;
        logic wrapped;
        logic wait_acks;
        logic notify_ack;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

    // Index width for a table dimension of n entries
    function automatic int f_index_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

/* hdl/wrwt_front.sv */
// ----------------------------------------------------------------------------
// wrwt_front
// Classifies incoming words: range checks and table address packing.
// ----------------------------------------------------------------------------
module wrwt_front #(
    parameter int COMM_SLOTS     = wrwt_pkg::COMM_SLOTS_DEF,
    parameter int RANKS_PER_COMM = wrwt_pkg::RANKS_PER_COMM_DEF,
    parameter int BOX_RANKS      = wrwt_pkg::BOX_RANKS_DEF,
    parameter int ADDR_BITS      = 2 + wrwt_pkg::f_index_bits(COMM_SLOTS)
                                     + wrwt_pkg::f_index_bits(RANKS_PER_COMM)
) (
    input  logic                               i_mode,
    input  logic [wrwt_pkg::KIND_BITS-1:0]     i_kind,
    input  logic [wrwt_pkg::COMM_BITS-1:0]     i_comm,
    input  logic [wrwt_pkg::RANK_BITS-1:0]     i_rank,
    output logic [ADDR_BITS-1:0]               o_addr,
    output wrwt_pkg::t_cmd_ctl                 o_ctl
);
    import wrwt_pkg::*;

    localparam int CW = f_index_bits(COMM_SLOTS);
    localparam int RW = f_index_bits(RANKS_PER_COMM);

    logic [31:0] comm_ext;
    logic [31:0] rank_ext;
    logic        scale_up;

    assign comm_ext = 32'(i_comm);
    assign rank_ext = 32'(i_rank);
    assign scale_up = ~i_kind[1];

    // Flag out-of-table and scale-up ranks beyond the box
    always_comb begin
        o_ctl.mode = t_mode'(i_mode);
        o_ctl.bad  = (comm_ext >= 32'(COMM_SLOTS)) ||
                     (rank_ext >= 32'(RANKS_PER_COMM)) ||
                     (scale_up && (rank_ext >= 32'(BOX_RANKS)));
    end

    // Pack kind, slot and rank into one table address
    assign o_addr = {i_kind, comm_ext[CW-1:0], rank_ext[RW-1:0]};

endmodule

/* hdl/wrwt_queue.sv */
// ----------------------------------------------------------------------------
// wrwt_queue
// Two-entry queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module wrwt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/wrwt_back.sv */
// ----------------------------------------------------------------------------
// wrwt_back
// Table engine: clears the tables after reset, then per item reads the counter,
// notify and wait entries, writes back those the item changes and holds the result word.
// ----------------------------------------------------------------------------
module wrwt_back #(
    parameter int COUNTER_BITS = wrwt_pkg::COUNTER_BITS_DEF,
    parameter int RANK_IDX     = 6,
    parameter int ADDR_BITS    = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [wrwt_pkg::WRAP_BITS-1:0]  i_wrap_log2,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  logic [ADDR_BITS-1:0]            i_q_addr,
    input  wrwt_pkg::t_cmd_ctl              i_q_ctl,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output wrwt_pkg::t_result               o_result
);
    import wrwt_pkg::*;

    localparam int DEPTH = 2 ** ADDR_BITS;

    // Tables
    logic [COUNTER_BITS-1:0] mem_cnt  [DEPTH];
    logic                    mem_ntf  [DEPTH];
    logic                    mem_wait [DEPTH];

    t_back_state             r_state, n_state;
    logic [ADDR_BITS-1:0]    r_clr_addr, n_clr_addr;
    logic [ADDR_BITS-1:0]    r_addr;
    t_cmd_ctl                r_ctl;
    logic [COUNTER_BITS-1:0] r_rd_cnt;
    logic                    r_rd_ntf;
    logic                    r_rd_wait;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_result, n_result;

    logic                    cnt_we, ntf_we, wait_we;
    logic [ADDR_BITS-1:0]    cnt_wa, ntf_wa, wait_wa;
    logic [COUNTER_BITS-1:0] cnt_wd;
    logic                    ntf_wd, wait_wd;

    logic [COUNTER_BITS-1:0] cnt_next;
    logic [COUNTER_BITS-1:0] wrap_mask;
    logic                    hit_wrap;
    logic                    scale_up;
    logic [ADDR_BITS-1:0]    target_addr;
    logic                    out_free;

    assign o_res_valid = r_out_valid;
    assign o_result    = r_result;
    assign out_free    = !r_out_valid || i_res_ready;

    // Wrap test on the incremented counter
    always_comb begin
        for (int i = 0; i < COUNTER_BITS; i++) begin
            wrap_mask[i] = (5'(i) < {1'b0, i_wrap_log2});
        end
    end
    assign cnt_next    = r_rd_cnt + COUNTER_BITS'(1);
    assign hit_wrap    = ((cnt_next & wrap_mask) == '0);
    assign scale_up    = ~r_addr[ADDR_BITS-1];
    assign target_addr = scale_up ? {r_addr[ADDR_BITS-1:RANK_IDX], RANK_IDX'(0)} : r_addr;

    // Next state, table writes and result
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_res_ready;
        n_result    = r_result;
        o_q_pop     = 1'b0;
        cnt_we      = 1'b0;
        ntf_we      = 1'b0;
        wait_we     = 1'b0;
        cnt_wa      = r_addr;
        ntf_wa      = r_addr;
        wait_wa     = r_addr;
        cnt_wd      = cnt_next;
        ntf_wd      = 1'b0;
        wait_wd     = r_rd_ntf;
        unique case (r_state)
            ST_CLEAR: begin
                cnt_we     = 1'b1;
                ntf_we     = 1'b1;
                wait_we    = 1'b1;
                cnt_wa     = r_clr_addr;
                ntf_wa     = r_clr_addr;
                wait_wa    = r_clr_addr;
                cnt_wd     = '0;
                wait_wd    = 1'b0;
                n_clr_addr = r_clr_addr + ADDR_BITS'(1);
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_result    = '0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_ctl.bad) begin
                        n_result.bad_rank = 1'b1;
                    end else if (r_ctl.mode == MODE_INC) begin
                        cnt_we           = 1'b1;
                        ntf_we           = hit_wrap;
                        ntf_wa           = target_addr;
                        ntf_wd           = 1'b1;
                        n_result.wrapped = hit_wrap;
                    end else begin
                        ntf_we              = 1'b1;
                        wait_we             = 1'b1;
                        n_result.notify_ack = r_rd_ntf;
                        n_result.wait_acks  = r_rd_wait;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Table write ports
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_wa] <= cnt_wd;
        end
        if (ntf_we) begin
            mem_ntf[ntf_wa] <= ntf_wd;
        end
        if (wait_we) begin
            mem_wait[wait_wa] <= wait_wd;
        end
    end

    // Read the table entry of the popped word; hold it while the result stalls
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_cnt  <= mem_cnt[i_q_addr];
            r_rd_ntf  <= mem_ntf[i_q_addr];
            r_rd_wait <= mem_wait[i_q_addr];
        end
    end

    // Latch the popped item and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_addr <= i_q_addr;
            r_ctl  <= i_q_ctl;
        end
        r_result <= n_result;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* hdl/work_request_wrap_tracker.sv */
// ----------------------------------------------------------------------------
// work_request_wrap_tracker
// Per-entry work-request counters with wrap notify and wait flags.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tuser mode, tdata kind/comm/rank
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata result flags
//   cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_data wrap_log2
//
// An item passes through the engine's idle state (registered table read) and
// exec state (modify and write); it pops no new item until the last is written.
// After reset a clearing pass writes all 2^ADDR_BITS entries, one per cycle
// (4096 entries at default sizing); the queue takes up to two items meanwhile
// but none is executed until the pass ends; config is taken throughout.
// The input queue holds two items, the result register one; a stalled output
// stops the engine, and a full queue drops s_axis_tready.
// ----------------------------------------------------------------------------
module work_request_wrap_tracker #(
    parameter int COMM_SLOTS     = wrwt_pkg::COMM_SLOTS_DEF,
    parameter int RANKS_PER_COMM = wrwt_pkg::RANKS_PER_COMM_DEF,
    parameter int BOX_RANKS      = wrwt_pkg::BOX_RANKS_DEF,
    parameter int COUNTER_BITS   = wrwt_pkg::COUNTER_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] queue_kind, [5:2] comm_index, [11:6] peer_rank, [15:12] zero
    input  logic [wrwt_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // [0] mode
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [0] notify_ack, [1] wait_acks, [2] wrapped, [3] bad_rank, [7:4] zero
    output logic [wrwt_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wrwt_pkg::WRAP_BITS-1:0]        i_cfg_data
);
    import wrwt_pkg::*;

    localparam int RW        = f_index_bits(RANKS_PER_COMM);
    localparam int ADDR_BITS = 2 + f_index_bits(COMM_SLOTS) + RW;
    localparam int QW        = ADDR_BITS + $bits(t_cmd_ctl);

    logic [WRAP_BITS-1:0] r_wrap_log2;
    logic [ADDR_BITS-1:0] front_addr;
    t_cmd_ctl             front_ctl;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_data;
    t_result              result;

    // Wrap size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_log2 <= WRAP_LOG2_RST;
        end else if (i_cfg_valid) begin
            r_wrap_log2 <= i_cfg_data;
        end
    end

    wrwt_front #(
        .COMM_SLOTS     (COMM_SLOTS),
        .RANKS_PER_COMM (RANKS_PER_COMM),
        .BOX_RANKS      (BOX_RANKS),
        .ADDR_BITS      (ADDR_BITS)
    ) u_front (
        .i_mode (s_axis_tuser),
        .i_kind (s_axis_tdata[1:0]),
        .i_comm (s_axis_tdata[5:2]),
        .i_rank (s_axis_tdata[11:6]),
        .o_addr (front_addr),
        .o_ctl  (front_ctl)
    );

    assign s_axis_tready = !q_full;

    wrwt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  ({front_addr, front_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    wrwt_back #(
        .COUNTER_BITS (COUNTER_BITS),
        .RANK_IDX     (RW),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wrap_log2 (r_wrap_log2),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_addr    (q_data[QW-1:$bits(t_cmd_ctl)]),
        .i_q_ctl     (t_cmd_ctl'(q_data[$bits(t_cmd_ctl)-1:0])),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {(OUT_DATA_BITS - $bits(t_result))'(0), result};

endmodule

/* sim/work_request_wrap_tracker_test.sv */
// ----------------------------------------------------------------------------
// work_request_wrap_tracker_test
// Self-checking bench for the work-request wrap tracker. A queue-fed driver
// posts increment and fetch words, a clocked monitor predicts each result from
// a local copy of the counter and flag tables and checks every result word.
// Covers rank rejects, wraps at rank 0 and at own rank, the flag hand-over on
// fetch, several wrap sizes and output back-pressure.
// ----------------------------------------------------------------------------
module work_request_wrap_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wrwt_pkg::*;

    localparam int      CLK_HALF     = 6;
    localparam int      RESET_CYCLES = 10;
    localparam longint  TIMEOUT_NS   = 10_000_000;
    localparam int      PHASE_ITEMS  = 115;
    localparam int      HOLD_CYCLES  = 300;
    localparam int      TABLE_SIZE   = 4 * COMM_SLOTS_DEF * RANKS_PER_COMM_DEF;
    localparam int      PRINT_LIMIT  = 40;

    typedef enum logic [1:0] {
        KIND_UP_GATHER  = 2'd0,
        KIND_UP_REDUCE  = 2'd1,
        KIND_OUT_GATHER = 2'd2,
        KIND_OUT_REDUCE = 2'd3
    } t_queue_kind;

    typedef struct packed {
        t_mode       mode;
        t_queue_kind kind;
        logic [3:0]  comm;
        logic [5:0]  rank;
    } t_wr_item;

    // DUT ports; the bench-driven inputs are known from time zero
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                     s_axis_tuser  = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    logic [WRAP_BITS-1:0]     i_cfg_data    = '0;

    // Local copy of the tracker tables and wrap size
    bit [COUNTER_BITS_DEF-1:0] wr_count   [TABLE_SIZE];
    bit                        notify_bit [TABLE_SIZE];
    bit                        wait_bit   [TABLE_SIZE];
    logic [WRAP_BITS-1:0]      wrap_sel = WRAP_LOG2_RST;

    t_wr_item request_q[$];
    t_result  pending_acks[$];
    t_wr_item next_req;

    bit in_fire    = 1'b0;
    bit idle_on    = 1'b1;
    bit hold_on    = 1'b0;
    int send_gap   = 0;
    int recv_stall = 0;

    int err_count   = 0;
    int posted      = 0;
    int checked     = 0;
    int wraps_seen  = 0;
    int rejects     = 0;
    int notify_seen = 0;
    int cfg_writes  = 0;

    work_request_wrap_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Apply one request to the local tables and return the result it earns
    function automatic t_result track_request(t_wr_item it);
        t_result                   res;
        int                        slot;
        bit [COUNTER_BITS_DEF-1:0] next_count;
        bit                        scale_up;
        res      = '0;
        scale_up = (it.kind == KIND_UP_GATHER) || (it.kind == KIND_UP_REDUCE);
        if (it.comm >= COMM_SLOTS_DEF || it.rank >= RANKS_PER_COMM_DEF ||
            (scale_up && it.rank >= BOX_RANKS_DEF)) begin
            res.bad_rank = 1'b1;
            return res;
        end
        slot = (int'(it.kind) * COMM_SLOTS_DEF + int'(it.comm)) * RANKS_PER_COMM_DEF
               + int'(it.rank);
        if (it.mode == MODE_INC) begin
            next_count     = wr_count[slot] + 1'b1;
            wr_count[slot] = next_count;
            if ((32'(next_count) & ((32'd1 << wrap_sel) - 32'd1)) == 32'd0) begin
                // scale-up kinds raise the flag of rank 0 in the same region
                notify_bit[scale_up ? slot - int'(it.rank) : slot] = 1'b1;
                res.wrapped = 1'b1;
            end
        end else begin
            res.notify_ack   = notify_bit[slot];
            res.wait_acks    = wait_bit[slot];
            wait_bit[slot]   = notify_bit[slot];
            notify_bit[slot] = 1'b0;
        end
        return res;
    endfunction

    function automatic t_wr_item wr_item(t_mode m, t_queue_kind k, int c, int r);
        t_wr_item it;
        it.mode = m;
        it.kind = k;
        it.comm = 4'(c);
        it.rank = 6'(r);
        return it;
    endfunction

    // Hot entries most of the time so counters wrap; full field range otherwise
    function automatic t_wr_item random_request();
        t_wr_item it;
        it.mode = ($urandom_range(0, 9) < 7) ? MODE_INC : MODE_FETCH;
        it.kind = t_queue_kind'($urandom_range(0, 3));
        it.comm = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
        if (it.kind == KIND_UP_GATHER || it.kind == KIND_UP_REDUCE) begin
            if ($urandom_range(0, 9) == 0)
                it.rank = 6'($urandom_range(BOX_RANKS_DEF, 63));
            else if ($urandom_range(0, 3) == 0)
                it.rank = '0;
            else
                it.rank = 6'($urandom_range(0, BOX_RANKS_DEF - 1));
        end else begin
            it.rank = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t: result %0d %s mismatch: got %0h, want %0h",
                     $time, checked, what, got, want);
    endtask

    task automatic check_ack(logic [OUT_DATA_BITS-1:0] word);
        t_result want;
        t_result got;
        if (pending_acks.size() == 0) begin
            report_mismatch("unexpected word", word, '0);
            return;
        end
        want = pending_acks.pop_front();
        got  = t_result'(word[3:0]);
        if (got.notify_ack !== want.notify_ack)
            report_mismatch("notify_ack", 8'(got.notify_ack), 8'(want.notify_ack));
        if (got.wait_acks !== want.wait_acks)
            report_mismatch("wait_acks", 8'(got.wait_acks), 8'(want.wait_acks));
        if (got.wrapped !== want.wrapped)
            report_mismatch("wrapped", 8'(got.wrapped), 8'(want.wrapped));
        if (got.bad_rank !== want.bad_rank)
            report_mismatch("bad_rank", 8'(got.bad_rank), 8'(want.bad_rank));
        if (word[OUT_DATA_BITS-1:4] !== '0)
            report_mismatch("padding", word, '0);
        checked++;
        wraps_seen  += int'(want.wrapped);
        rejects     += int'(want.bad_rank);
        notify_seen += int'(want.notify_ack);
    endtask

    // Check results, then predict newly accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_ack(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                pending_acks.push_back(track_request(t_wr_item'({s_axis_tuser,
                                                               s_axis_tdata[1:0],
                                                               s_axis_tdata[5:2],
                                                               s_axis_tdata[11:6]})));
                posted++;
            end
        end
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Drive request words with random gap bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_fire || !s_axis_tvalid) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                next_req = request_q.pop_front();
                s_axis_tdata  <= IN_DATA_BITS'({next_req.rank, next_req.comm, next_req.kind});
                s_axis_tuser  <= next_req.mode;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Drive result ready: long hold when asked, else random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Write the wrap size; returns at a rising edge
    task automatic write_wrap(logic [WRAP_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        wrap_sel = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_q.size() != 0 || pending_acks.size() != 0 || s_axis_tvalid);
    endtask

    task automatic queue_random(int count);
        repeat (count) request_q.push_back(random_request());
    endtask

    initial begin
        logic [WRAP_BITS-1:0] wrap_plan [5];
        wrap_plan = '{4'd1, 4'd2, 4'd15, 4'd6, WRAP_BITS'($urandom_range(4, 14))};

        // Hold reset, then release
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fresh entry, rank rejects, scale-up wrap and flag hand-over
        request_q.push_back(wr_item(MODE_FETCH, KIND_UP_GATHER, 0, 0));
        request_q.push_back(wr_item(MODE_INC, KIND_UP_GATHER, 0, 8));
        request_q.push_back(wr_item(MODE_FETCH, KIND_UP_REDUCE, 0, 63));
        request_q.push_back(wr_item(MODE_INC, KIND_UP_GATHER, 15, 63));
        request_q.push_back(wr_item(MODE_INC, KIND_OUT_REDUCE, 15, 63));
        repeat (8) request_q.push_back(wr_item(MODE_INC, KIND_UP_REDUCE, 15, 7));
        repeat (3) request_q.push_back(wr_item(MODE_FETCH, KIND_UP_REDUCE, 15, 0));
        request_q.push_back(wr_item(MODE_FETCH, KIND_UP_REDUCE, 15, 7));
        wait_drained();

        // Directed: wrap size zero makes every increment wrap
        write_wrap('0);
        request_q.push_back(wr_item(MODE_INC, KIND_OUT_GATHER, 3, 40));
        request_q.push_back(wr_item(MODE_FETCH, KIND_OUT_GATHER, 3, 40));
        request_q.push_back(wr_item(MODE_INC, KIND_UP_GATHER, 5, 3));
        request_q.push_back(wr_item(MODE_FETCH, KIND_UP_GATHER, 5, 0));
        wait_drained();

        // Random phases over several wrap sizes
        for (int p = 0; p < 5; p++) begin
            write_wrap(wrap_plan[p]);
            if (p == 1) begin
                // Block the result side long enough for the input to back up
                hold_on = 1'b1;
                queue_random(40);
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
                queue_random(PHASE_ITEMS - 40);
            end else begin
                queue_random(PHASE_ITEMS);
            end
            wait_drained();
        end

        // Closing phase with no idling on either side
        idle_on = 1'b0;
        write_wrap(WRAP_BITS'($urandom_range(1, 14)));
        queue_random(PHASE_ITEMS);
        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("Posted %0d requests over %0d wrap size writes; %0d results checked.",
                 posted, cfg_writes, checked);
        $display("Saw %0d wraps, %0d rank rejects, %0d notify acks; %0d mismatches.",
                 wraps_seen, rejects, notify_seen, err_count);
        if (err_count == 0 && pending_acks.size() == 0) begin
            $display("work_request_wrap_tracker verification clean");
        end else begin
            $display("work_request_wrap_tracker verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $display("Timeout with %0d requests queued and %0d results outstanding.",
                 request_q.size(), pending_acks.size());
        $display("work_request_wrap_tracker verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/wrwt_pkg.sv
hdl/wrwt_front.sv
hdl/wrwt_queue.sv
hdl/wrwt_back.sv
hdl/work_request_wrap_tracker.sv
sim/work_request_wrap_tracker_test.sv
